FILE: sv/qsort_pkg.sv
// types, constants and microprogram of the quicksort batch sorter
package qsort_pkg;

	localparam int MAX_ELEMENTS = 64;
	localparam int IDX_W = $clog2(MAX_ELEMENTS);
	localparam int CNT_W = IDX_W + 1;
	localparam int DATA_W = 32;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// input transaction payload
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic is_last;
	} item_t;

	// output transaction payload
	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic end_of_run;
		logic overflow;
	} result_t;

	// one entry of the range stack
	typedef struct packed {
		idx_t lo;
		idx_t hi;
	} range_t;

	// datapath operation of one microcode step
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_SINIT,
		OP_POP,
		OP_RANGE,
		OP_PIVOT,
		OP_TEST,
		OP_SWAP_K,
		OP_SWAP_SLOT,
		OP_ADV,
		OP_FIN_RD,
		OP_FIN_HI,
		OP_FIN_SLOT,
		OP_PUSH_R,
		OP_PUSH_L,
		OP_EMIT_RD,
		OP_EMIT_LOAD,
		OP_EMIT_WAIT,
		OP_FINISH
	} op_t;

	// sequencing of one microcode step
	typedef enum logic [2:0] {
		SQ_NEXT,
		SQ_GOTO,
		SQ_WAIT_CLOSE,
		SQ_IF_SMALL,
		SQ_IF_EMPTY,
		SQ_IF_NOT_LESS,
		SQ_IF_MORE,
		SQ_WAIT_OUT
	} seq_t;

	// microcode addresses
	typedef enum logic [4:0] {
		UA_LOAD,
		UA_SINIT,
		UA_POP,
		UA_RANGE,
		UA_PIVOT,
		UA_TEST,
		UA_SWAP_K,
		UA_SWAP_SLOT,
		UA_ADV,
		UA_FIN_RD,
		UA_FIN_HI,
		UA_FIN_SLOT,
		UA_PUSH_R,
		UA_PUSH_L,
		UA_EMIT_RD,
		UA_EMIT_LOAD,
		UA_EMIT_WAIT,
		UA_FINISH
	} upc_t;

	typedef struct packed {
		op_t op;
		seq_t seq;
		upc_t target;
	} ucode_t;

	// microprogram rom
	function automatic ucode_t ucode_rom(upc_t addr);
		ucode_t w;
		unique case (addr)
			UA_LOAD:      w = '{OP_LOAD,      SQ_WAIT_CLOSE,  UA_LOAD};
			UA_SINIT:     w = '{OP_SINIT,     SQ_IF_SMALL,    UA_EMIT_RD};
			UA_POP:       w = '{OP_POP,       SQ_IF_EMPTY,    UA_EMIT_RD};
			UA_RANGE:     w = '{OP_RANGE,     SQ_NEXT,        UA_LOAD};
			UA_PIVOT:     w = '{OP_PIVOT,     SQ_NEXT,        UA_LOAD};
			UA_TEST:      w = '{OP_TEST,      SQ_IF_NOT_LESS, UA_ADV};
			UA_SWAP_K:    w = '{OP_SWAP_K,    SQ_NEXT,        UA_LOAD};
			UA_SWAP_SLOT: w = '{OP_SWAP_SLOT, SQ_NEXT,        UA_LOAD};
			UA_ADV:       w = '{OP_ADV,       SQ_IF_MORE,     UA_TEST};
			UA_FIN_RD:    w = '{OP_FIN_RD,    SQ_NEXT,        UA_LOAD};
			UA_FIN_HI:    w = '{OP_FIN_HI,    SQ_NEXT,        UA_LOAD};
			UA_FIN_SLOT:  w = '{OP_FIN_SLOT,  SQ_NEXT,        UA_LOAD};
			UA_PUSH_R:    w = '{OP_PUSH_R,    SQ_NEXT,        UA_LOAD};
			UA_PUSH_L:    w = '{OP_PUSH_L,    SQ_GOTO,        UA_POP};
			UA_EMIT_RD:   w = '{OP_EMIT_RD,   SQ_NEXT,        UA_LOAD};
			UA_EMIT_LOAD: w = '{OP_EMIT_LOAD, SQ_NEXT,        UA_LOAD};
			UA_EMIT_WAIT: w = '{OP_EMIT_WAIT, SQ_WAIT_OUT,    UA_EMIT_RD};
			UA_FINISH:    w = '{OP_FINISH,    SQ_GOTO,        UA_LOAD};
			default:      w = '{OP_NONE,      SQ_GOTO,        UA_LOAD};
		endcase
		return w;
	endfunction

endpackage

FILE: sv/quicksort_batch_sorter.sv
// Batch sorter top level: loads a batch, sorts it by quicksort, streams it out.
//
// Input channel item_valid/item_ready/item carries one signed 32-bit value per
// transaction; item.is_last closes the batch. Up to MAX_ELEMENTS values are
// kept, later ones are dropped and every result of that batch has overflow set.
// Output channel result_valid/result_ready/result carries the batch in ascending
// order; end_of_run marks the last value. A closing transaction always yields
// at least one result.
// Loading takes one transaction per cycle. After the closing transaction a
// microcoded sequencer sorts the store in place with one element memory, which
// has a write port and a registered read port, and a range stack; the sort
// takes roughly N log N element steps on average. Each result is read from the
// element memory only after the previous one is taken.
// No new item is accepted from the closing transaction until the last result
// is taken. A stalled receiver holds the current result and the sequencer.
// Reset returns the block to loading an empty batch; no clearing pass is run.
module quicksort_batch_sorter
	import qsort_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	// microcode sequencer state
	upc_t   upc_q, upc_d, upc_inc;
	ucode_t uw;

	// datapath registers
	cnt_t   cnt_q, sp_q;
	logic   drop_q;
	logic   out_valid_q;
	result_t out_q;
	idx_t   lo_q, hi_q, slot_q, k_q;
	logic signed [DATA_W-1:0] pivot_q, a_q, mem_rd_q;
	range_t stk_rd_q;

	// memories
	logic signed [DATA_W-1:0] store_mem [MAX_ELEMENTS];
	range_t stack_mem [MAX_ELEMENTS];

	// memory port controls
	logic   mem_we;
	idx_t   mem_wa, mem_ra;
	logic signed [DATA_W-1:0] mem_wd;
	logic   stk_we;
	range_t stk_wd;

	// flags
	logic   item_acc, out_acc, close_flag, small_flag, empty_flag, less_flag, more_flag;
	logic   push_r_ok, push_l_ok, stk_room;
	cnt_t   k_inc, slot_inc, lo_inc;

	assign uw = ucode_rom(upc_q);
	assign upc_inc = upc_t'(upc_q + 5'd1);

	assign item_ready   = (uw.op == OP_LOAD);
	assign result_valid = out_valid_q;
	assign result       = out_q;

	assign item_acc   = item_valid && item_ready;
	assign out_acc    = out_valid_q && result_ready;
	assign close_flag = item_acc && item.is_last;
	assign small_flag = cnt_q < cnt_t'(2);
	assign empty_flag = (sp_q == '0);
	assign less_flag  = mem_rd_q < pivot_q;
	assign k_inc      = {1'b0, k_q} + cnt_t'(1);
	assign slot_inc   = {1'b0, slot_q} + cnt_t'(1);
	assign lo_inc     = {1'b0, lo_q} + cnt_t'(1);
	assign more_flag  = (k_inc != {1'b0, hi_q});
	assign push_r_ok  = slot_inc < {1'b0, hi_q};
	assign push_l_ok  = lo_inc < {1'b0, slot_q};
	assign stk_room   = sp_q < cnt_t'(MAX_ELEMENTS);

	// next microcode address
	always_comb begin
		upc_d = upc_q;
		unique case (uw.seq)
			SQ_NEXT:        upc_d = upc_inc;
			SQ_GOTO:        upc_d = uw.target;
			SQ_WAIT_CLOSE:  upc_d = close_flag ? upc_inc : upc_q;
			SQ_IF_SMALL:    upc_d = small_flag ? uw.target : upc_inc;
			SQ_IF_EMPTY:    upc_d = empty_flag ? uw.target : upc_inc;
			SQ_IF_NOT_LESS: upc_d = less_flag ? upc_inc : uw.target;
			SQ_IF_MORE:     upc_d = more_flag ? uw.target : upc_inc;
			SQ_WAIT_OUT: begin
				if (out_acc) begin
					upc_d = out_q.end_of_run ? upc_inc : uw.target;
				end
			end
			default:        upc_d = UA_LOAD;
		endcase
	end

	// element memory port decode
	always_comb begin
		mem_we = 1'b0;
		mem_wa = k_q;
		mem_wd = mem_rd_q;
		mem_ra = k_q;
		unique case (uw.op)
			OP_LOAD: begin
				mem_we = item_acc && (cnt_q < cnt_t'(MAX_ELEMENTS));
				mem_wa = idx_t'(cnt_q);
				mem_wd = item.value;
			end
			OP_RANGE:     mem_ra = stk_rd_q.hi;
			OP_TEST:      mem_ra = slot_q;
			OP_ADV:       mem_ra = idx_t'(k_inc);
			OP_FIN_RD:    mem_ra = slot_q;
			OP_SWAP_K:    mem_we = 1'b1;
			OP_SWAP_SLOT: begin
				mem_we = 1'b1;
				mem_wa = slot_q;
				mem_wd = a_q;
			end
			OP_FIN_HI: begin
				mem_we = 1'b1;
				mem_wa = hi_q;
			end
			OP_FIN_SLOT: begin
				mem_we = 1'b1;
				mem_wa = slot_q;
				mem_wd = pivot_q;
			end
			default: ;
		endcase
	end

	// range stack push decode
	always_comb begin
		stk_we = 1'b0;
		stk_wd = '{lo: slot_q, hi: hi_q};
		unique case (uw.op)
			OP_SINIT: begin
				stk_we = 1'b1;
				stk_wd = '{lo: '0, hi: idx_t'(cnt_q - cnt_t'(1))};
			end
			OP_PUSH_R: begin
				stk_we = push_r_ok && stk_room;
				stk_wd = '{lo: idx_t'(slot_inc), hi: hi_q};
			end
			OP_PUSH_L: begin
				stk_we = push_l_ok && stk_room;
				stk_wd = '{lo: lo_q, hi: slot_q - idx_t'(1)};
			end
			default: ;
		endcase
	end

	// element memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[mem_wa] <= mem_wd;
		end
		mem_rd_q <= store_mem[mem_ra];
	end

	// range stack memory, read port always looks at the top entry
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stack_mem[idx_t'(sp_q)] <= stk_wd;
		end
		stk_rd_q <= stack_mem[idx_t'(sp_q - cnt_t'(1))];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q       <= UA_LOAD;
			cnt_q       <= '0;
			sp_q        <= '0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			upc_q <= upc_d;
			if (stk_we) begin
				sp_q <= sp_q + cnt_t'(1);
			end
			unique case (uw.op)
				OP_LOAD: begin
					if (item_acc) begin
						if (cnt_q < cnt_t'(MAX_ELEMENTS)) begin
							cnt_q <= cnt_q + cnt_t'(1);
						end else begin
							drop_q <= 1'b1;
						end
					end
				end
				OP_POP: begin
					if (!empty_flag) begin
						sp_q <= sp_q - cnt_t'(1);
					end
				end
				OP_EMIT_LOAD: out_valid_q <= 1'b1;
				OP_EMIT_WAIT: begin
					if (out_acc) begin
						out_valid_q <= 1'b0;
					end
				end
				OP_FINISH: begin
					cnt_q  <= '0;
					sp_q   <= '0;
					drop_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// payload and index registers
	always_ff @(posedge clk) begin
		case (uw.op)
			OP_SINIT: k_q <= '0;
			OP_POP: begin
				if (empty_flag) begin
					k_q <= '0;
				end
			end
			OP_RANGE: begin
				lo_q   <= stk_rd_q.lo;
				hi_q   <= stk_rd_q.hi;
				slot_q <= stk_rd_q.lo;
				k_q    <= stk_rd_q.lo;
			end
			OP_PIVOT:     pivot_q <= mem_rd_q;
			OP_TEST:      a_q <= mem_rd_q;
			OP_SWAP_SLOT: slot_q <= idx_t'(slot_inc);
			OP_ADV:       k_q <= idx_t'(k_inc);
			OP_EMIT_LOAD: begin
				out_q.sorted_value <= mem_rd_q;
				out_q.end_of_run   <= (k_inc == cnt_q);
				out_q.overflow     <= drop_q;
			end
			OP_EMIT_WAIT: begin
				if (out_acc) begin
					k_q <= idx_t'(k_inc);
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	// loading and output never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(item_ready && result_valid))
		else $error("item_ready while a result is pending");

	// disjoint ranges of two or more keep the stack at most half deep
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= cnt_t'(MAX_ELEMENTS / 2))
		else $error("range stack deeper than expected");

	// partition scan stays inside its range
	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		(uw.op == OP_TEST) |-> (slot_q <= k_q && k_q < hi_q))
		else $error("partition indices out of order");

	// the last result of a batch leads to the batch wrap-up
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && out_q.end_of_run) |=> (upc_q == UA_FINISH))
		else $error("batch not closed after last result");
`endif

endmodule

FILE: test/quicksort_batch_sorter_tb.sv
// self-checking testbench for the quicksort batch sorter
`timescale 1ns / 100ps

module quicksort_batch_sorter_tb;
	import qsort_pkg::*;

	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
	localparam int HOLD_CYCLES = 500;

	// how the values of one batch are chosen
	typedef enum int {
		FILL_WIDE,
		FILL_NARROW,
		FILL_EDGE,
		FILL_RISING,
		FILL_FALLING
	} fill_t;

	// one queued input transaction, optionally waiting for the block to drain first
	typedef struct packed {
		item_t payload;
		logic drain_first;
	} backlog_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;

	backlog_t item_backlog[$];
	result_t pending_sorted[$];

	// running copy of the block's batch state
	logic signed [DATA_W-1:0] held_values[MAX_ELEMENTS];
	int held_count = 0;
	logic batch_dropped = 1'b0;

	int items_total = 0;
	int items_taken = 0;
	int batches_closed = 0;
	int overflow_batches = 0;
	int values_checked = 0;
	int faults = 0;
	logic tail_calm = 1'b0;

	int send_gap;
	int take_gap;
	int hold_left;
	logic hold_done;
	int taken_here;

	quicksort_batch_sorter dut (
		.clk,
		.arst_n,
		.item_valid,
		.item_ready,
		.item,
		.result_valid,
		.result_ready,
		.result
	);

	// clock
	initial begin
		forever #2 clk = ~clk;
	end

	// in-place quicksort of the held values, lomuto partition, explicit range stack
	task automatic sort_held(input int n);
		int lo_stack[$];
		int hi_stack[$];
		int lo;
		int hi;
		int slot;
		logic signed [DATA_W-1:0] pivot;
		logic signed [DATA_W-1:0] tmp;
		if (n < 2)
			return;
		lo_stack.push_back(0);
		hi_stack.push_back(n - 1);
		while (lo_stack.size() > 0) begin
			lo = lo_stack.pop_back();
			hi = hi_stack.pop_back();
			pivot = held_values[hi];
			slot = lo;
			for (int k = lo; k < hi; k++) begin
				if (held_values[k] < pivot) begin
					tmp = held_values[slot];
					held_values[slot] = held_values[k];
					held_values[k] = tmp;
					slot++;
				end
			end
			tmp = held_values[slot];
			held_values[slot] = held_values[hi];
			held_values[hi] = tmp;
			// right part first so the left part comes off the stack first
			if (slot + 1 < hi) begin
				lo_stack.push_back(slot + 1);
				hi_stack.push_back(hi);
			end
			if (slot - 1 > lo) begin
				lo_stack.push_back(lo);
				hi_stack.push_back(slot - 1);
			end
		end
	endtask

	// update the batch state with one accepted transaction, predict results on close
	task automatic absorb_item(input item_t it);
		result_t r;
		if (held_count < MAX_ELEMENTS) begin
			held_values[held_count] = it.value;
			held_count++;
		end else begin
			batch_dropped = 1'b1;
		end
		if (it.is_last) begin
			sort_held(held_count);
			for (int k = 0; k < held_count; k++) begin
				r.sorted_value = held_values[k];
				r.end_of_run = (k == held_count - 1);
				r.overflow = batch_dropped;
				pending_sorted.push_back(r);
			end
			batches_closed++;
			if (batch_dropped)
				overflow_batches++;
			held_count = 0;
			batch_dropped = 1'b0;
		end
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value(input fill_t fill, input int pos,
			input int base);
		logic signed [DATA_W-1:0] v;
		case (fill)
			FILL_NARROW: v = $urandom_range(0, 6) - 3;
			FILL_EDGE: begin
				case ($urandom_range(0, 4))
					0: v = VAL_MIN;
					1: v = VAL_MAX;
					2: v = 0;
					3: v = -1;
					default: v = 1;
				endcase
			end
			FILL_RISING: v = base + pos * 3;
			FILL_FALLING: v = base - pos * 3;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic queue_value(input logic signed [DATA_W-1:0] v, input logic last,
			input logic drain);
		backlog_t b;
		b.payload.value = v;
		b.payload.is_last = last;
		b.drain_first = drain;
		item_backlog.push_back(b);
		items_total++;
	endtask

	task automatic queue_batch(input int size, input fill_t fill, input logic drain);
		int base;
		base = $urandom_range(0, 2000) - 1000;
		for (int p = 0; p < size; p++)
			queue_value(pick_value(fill, p, base), p == size - 1, drain && p == 0);
	endtask

	// sender: presents backlog transactions, with random gaps and drain pauses
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			tail_calm <= 1'b0;
			send_gap = 0;
		end else begin
			if (item_valid && item_ready) begin
				absorb_item(item);
				items_taken++;
			end
			tail_calm <= (item_backlog.size() < 40);
			if (!item_valid || item_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					item_valid <= 1'b0;
				end else if (item_backlog.size() == 0) begin
					item_valid <= 1'b0;
				end else if (item_backlog[0].drain_first && pending_sorted.size() != 0) begin
					item_valid <= 1'b0;
				end else if (!tail_calm && $urandom_range(0, 11) == 0) begin
					send_gap = $urandom_range(0, 12);
					item_valid <= 1'b0;
				end else begin
					item <= item_backlog[0].payload;
					item_valid <= 1'b1;
					void'(item_backlog.pop_front());
				end
			end
		end
	end

	// receiver: random stalls plus one long hold-off once results are flowing
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			take_gap = 0;
			hold_left = 0;
			hold_done = 1'b0;
			taken_here = 0;
		end else begin
			if (result_valid && result_ready)
				taken_here++;
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (!hold_done && taken_here >= 40) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				result_ready <= 1'b0;
			end else if (take_gap > 0) begin
				take_gap--;
				result_ready <= 1'b0;
			end else if (!tail_calm && $urandom_range(0, 7) == 0) begin
				take_gap = $urandom_range(0, 12);
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// compare every result transaction with the oldest predicted one
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_sorted.size() == 0) begin
				$error("unexpected result: sorted_value %0d", result.sorted_value);
				faults++;
			end else begin
				want = pending_sorted.pop_front();
				values_checked++;
				if (result.sorted_value !== want.sorted_value) begin
					$error("sorted_value: expected %0d, got %0d", want.sorted_value,
						result.sorted_value);
					faults++;
				end
				if (result.end_of_run !== want.end_of_run) begin
					$error("end_of_run: expected %0b, got %0b", want.end_of_run,
						result.end_of_run);
					faults++;
				end
				if (result.overflow !== want.overflow) begin
					$error("overflow: expected %0b, got %0b", want.overflow, result.overflow);
					faults++;
				end
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		int pick;

		// directed: lone extremes, mixed extremes, two elements, duplicates, sorted runs
		queue_value(VAL_MIN, 1'b1, 1'b0);
		queue_value(VAL_MAX, 1'b1, 1'b0);
		queue_value(VAL_MAX, 1'b0, 1'b0);
		queue_value(VAL_MIN, 1'b0, 1'b0);
		queue_value(0, 1'b0, 1'b0);
		queue_value(-1, 1'b0, 1'b0);
		queue_value(1, 1'b1, 1'b0);
		queue_value(5, 1'b0, 1'b0);
		queue_value(-5, 1'b1, 1'b0);
		for (int p = 0; p < 4; p++)
			queue_value(-7, p == 3, 1'b0);
		queue_batch(5, FILL_RISING, 1'b0);
		queue_batch(5, FILL_FALLING, 1'b0);

		// full store, then a batch whose closing transaction is dropped
		queue_batch(MAX_ELEMENTS, FILL_RISING, 1'b1);
		queue_batch(MAX_ELEMENTS + 3, FILL_WIDE, 1'b0);

		// random batches, mostly small
		while (items_total < 430) begin
			pick = $urandom_range(0, 99);
			if (pick < 75)
				queue_batch($urandom_range(1, 8), fill_t'($urandom_range(0, 4)),
					$urandom_range(0, 19) == 0);
			else if (pick < 93)
				queue_batch($urandom_range(9, 30), fill_t'($urandom_range(0, 4)), 1'b0);
			else
				queue_batch($urandom_range(MAX_ELEMENTS - 4, MAX_ELEMENTS + 6),
					fill_t'($urandom_range(0, 4)), 1'b0);
		end

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (items_taken != items_total)
			@(posedge clk);
		while (pending_sorted.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		$display("sorted %0d batches from %0d items, %0d of them over capacity",
			batches_closed, items_total, overflow_batches);
		$display("%0d sorted values checked, %0d mismatches", values_checked, faults);
		if (faults == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

FILE: sim.f
sv/qsort_pkg.sv
sv/quicksort_batch_sorter.sv
test/quicksort_batch_sorter_tb.sv
